// File: rtl/core/me_pkg.sv
// Shared constants and types for the modular exponentiation block.
// Depends on nothing; every other file of the block uses it.
package me_pkg;

  // Operand width of modulus, exponent, message and result.
  localparam int Width = 32;
  // Bits of a counter that steps through the operand bits.
  localparam int CntW = $clog2(Width);

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgModulus  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgExponent = 1'b1;

  // Status of one modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// File: rtl/core/me_if.sv
// Stream interfaces for the message input and the result output.
// Depends on me_pkg for the operand width.
interface me_in_if;
  logic                     valid;
  logic                     ready;
  logic [me_pkg::Width-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

interface me_out_if;
  logic                     valid;
  logic                     ready;
  logic [me_pkg::Width-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

// File: rtl/core/me_mulmod.sv
// Bit-serial interleaved modular multiplier: r = a * b mod m, one bit of b per cycle.
// Depends on me_pkg. Requires a < m and m nonzero when started; b may be any value.
module me_mulmod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [me_pkg::Width-1:0] a_i,
  input  logic [me_pkg::Width-1:0] b_i,
  input  logic [me_pkg::Width-1:0] m_i,
  output logic [me_pkg::Width-1:0] r_o,
  output me_pkg::mm_stat_t         stat_o
);
  import me_pkg::*;

  logic [Width-1:0] r_q, r_d;
  logic [Width-1:0] a_q, a_d;
  logic [Width-1:0] b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [Width+1:0] sum;
  logic [Width+2:0] diff1;
  logic [Width+2:0] diff2;
  logic [Width-1:0] r_step;

  // One step: double the partial result, add a if the current bit of b is set,
  // then bring the sum (below three times m) back under m.
  always_comb begin
    sum   = {1'b0, r_q, 1'b0} + (b_q[Width-1] ? {2'b00, a_q} : '0);
    diff1 = {1'b0, sum} - {3'b000, m_i};
    diff2 = {1'b0, sum} - {2'b00, m_i, 1'b0};
    if (!diff2[Width+2]) begin
      r_step = diff2[Width-1:0];
    end else if (!diff1[Width+2]) begin
      r_step = diff1[Width-1:0];
    end else begin
      r_step = sum[Width-1:0];
    end
  end

  // Sequencing: load on start, then walk through b from its top bit down.
  always_comb begin
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = r_step;
      b_d   = {b_q[Width-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Width - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign r_o         = r_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation block: message ** exponent mod modulus.
// Depends on me_pkg, the interfaces in me_if and two me_mulmod multipliers.
//
//   channel   dir  handshake        payload
//   msg_i     in   valid / ready    message       (Width bits, unsigned)
//   res_o     out  valid / ready    power_result  (Width bits, unsigned)
//   cfg       in   cfg_we_i         cfg_index_i, cfg_wdata_i (modulus, exponent)
//
// An item with a zero exponent or a zero modulus goes from its transfer to the finish
// state and from there into the output register once that is free. Otherwise the
// message is first reduced by one pass of a multiplier, then Width rounds of
// square-and-multiply follow, each with the two bit-serial multipliers running side
// by side. One item is worked on at a time; a new message is taken while the
// previous result still waits in the output register. Reset sets modulus and
// exponent to 1 and empties the output register.
module modular_exponentiation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [me_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [me_pkg::Width-1:0]   cfg_wdata_i,
  me_in_if.sink                      msg_i,
  me_out_if.source                   res_o
);
  import me_pkg::*;

  localparam logic [2:0] StIdle       = 3'd0;
  localparam logic [2:0] StReduce     = 3'd1;
  localparam logic [2:0] StRoundStart = 3'd2;
  localparam logic [2:0] StRoundWait  = 3'd3;
  localparam logic [2:0] StFinish     = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [Width-1:0] modulus_q, modulus_d;
  logic [Width-1:0] exponent_q, exponent_d;
  logic [Width-1:0] acc_q, acc_d;
  logic [Width-1:0] base_q, base_d;
  logic [Width-1:0] exp_q, exp_d;
  logic [CntW-1:0]  rnd_q, rnd_d;
  logic [Width-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             in_xfer;
  logic             out_load;
  logic [Width-1:0] one_mod;
  logic             start_a, start_b;
  logic [Width-1:0] a_a, b_a;
  logic [Width-1:0] res_a, res_b;
  mm_stat_t         stat_a, stat_b;

  assign in_xfer = msg_i.valid && msg_i.ready;
  // One reduced modulo the modulus: zero when the modulus is one.
  assign one_mod = {{(Width-1){1'b0}}, (modulus_q != {{(Width-1){1'b0}}, 1'b1})};

  // Multiplier A reduces the message first (one_mod * message), then forms
  // acc * base in each round. Multiplier B squares the base.
  assign start_a = (state_q == StIdle && in_xfer && exponent_q != '0 && modulus_q != '0)
                   || (state_q == StRoundStart);
  assign start_b = (state_q == StRoundStart);
  assign a_a     = (state_q == StIdle) ? one_mod : acc_q;
  assign b_a     = (state_q == StIdle) ? msg_i.message : base_q;

  me_mulmod u_mul_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_a),
    .a_i    (a_a),
    .b_i    (b_a),
    .m_i    (modulus_q),
    .r_o    (res_a),
    .stat_o (stat_a)
  );

  me_mulmod u_mul_sqr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_b),
    .a_i    (base_q),
    .b_i    (base_q),
    .m_i    (modulus_q),
    .r_o    (res_b),
    .stat_o (stat_b)
  );

  // Configuration registers.
  always_comb begin
    modulus_d  = modulus_q;
    exponent_d = exponent_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgModulus:  modulus_d  = cfg_wdata_i;
        CfgExponent: exponent_d = cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Sequencer over reduction, rounds and the output register.
  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    base_d   = base_q;
    exp_d    = exp_q;
    rnd_d    = rnd_q;
    out_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (exponent_q == '0) begin
            acc_d   = {{(Width-1){1'b0}}, 1'b1};
            state_d = StFinish;
          end else if (modulus_q == '0) begin
            acc_d   = '0;
            state_d = StFinish;
          end else begin
            state_d = StReduce;
          end
        end
      end
      StReduce: begin
        if (stat_a.done) begin
          base_d  = res_a;
          acc_d   = one_mod;
          exp_d   = exponent_q;
          rnd_d   = '0;
          state_d = StRoundStart;
        end
      end
      StRoundStart: begin
        state_d = StRoundWait;
      end
      StRoundWait: begin
        if (stat_a.done) begin
          if (exp_q[0]) begin
            acc_d = res_a;
          end
          base_d = res_b;
          exp_d  = {1'b0, exp_q[Width-1:1]};
          rnd_d  = rnd_q + 1'b1;
          if (rnd_q == CntW'(Width - 1)) begin
            state_d = StFinish;
          end else begin
            state_d = StRoundStart;
          end
        end
      end
      StFinish: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: holds a result until its transfer.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = acc_q;
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      modulus_q   <= {{(Width-1){1'b0}}, 1'b1};
      exponent_q  <= {{(Width-1){1'b0}}, 1'b1};
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      modulus_q   <= modulus_d;
      exponent_q  <= exponent_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    out_q  <= out_d;
  end

  assign msg_i.ready        = (state_q == StIdle);
  assign res_o.valid        = out_valid_q;
  assign res_o.power_result = out_q;

  // A transfer always starts work on the item.
  a_xfer_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != StIdle)
    else $error("accepted message left the block idle");

  // Both multipliers finish in the same cycle of a round.
  a_mul_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRoundWait |-> stat_a.done == stat_b.done)
    else $error("multipliers out of step");

  // A round is only started with both multipliers free.
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRoundStart |-> !stat_a.busy && !stat_b.busy)
    else $error("round started while a multiplier is busy");

  // A finished result waits while the output register is still occupied.
  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && out_valid_q && !res_o.ready) |=> state_q == StFinish)
    else $error("result loaded over a pending one");

endmodule

// File: verif/modular_exponentiation_tb.sv
// Testbench for modular_exponentiation: drives messages under several modulus and exponent
// settings; checks every result against a known value or a square-and-multiply predictor.
// Depends on me_pkg, the me_in_if and me_out_if interfaces and the block's RTL.
`timescale 1ns / 100ps

module modular_exponentiation_tb;
  import me_pkg::*;

  typedef logic [Width-1:0]   word_t;
  typedef logic [2*Width-1:0] dword_t;

  // One directed row: configuration, message and, where obvious, the result.
  typedef struct packed {
    logic [31:0] modulus;
    logic [31:0] exponent;
    logic [31:0] message;
    logic        known;
    logic [31:0] power;
  } dir_row_t;

  localparam int CycleLimit = 4_000_000;
  localparam int TailCycles = 40;
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 65;
  localparam int NumDir     = 24;

  localparam dir_row_t DirTab [NumDir] = '{
    // Reset configuration: modulus 1 sends everything to zero.
    '{32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    // Exponent zero gives one, whatever the modulus.
    '{32'h0000_0001, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0007, 1'b1, 32'h0000_0001},
    // Modulus zero with a nonzero exponent gives zero.
    '{32'h0000_0000, 32'h0000_0003, 32'h0000_0007, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    // Messages at and above the modulus are reduced first.
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0002, 1'b1, 32'h0000_0004},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
    // Textbook RSA pair: encrypt, encrypt of an unreduced message, decrypt.
    '{32'd3233,      32'd17,        32'd65,        1'b0, 32'h0000_0000},
    '{32'd3233,      32'd17,        32'd3298,      1'b0, 32'h0000_0000},
    '{32'd3233,      32'd2753,      32'd2790,      1'b0, 32'h0000_0000},
    // Fermat: largest 32-bit prime, exponent p - 1.
    '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'h89AB_CDEF, 1'b0, 32'h0000_0000},
    '{32'h8000_0000, 32'h8000_0000, 32'h0000_0003, 1'b0, 32'h0000_0000},
    '{32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'h0001_0001, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  word_t cfg_wdata_i;

  me_in_if  msg_if ();
  me_out_if res_if ();

  // Shadow copy of the configuration registers.
  word_t cur_modulus;
  word_t cur_exponent;

  // Powers still owed by the block, oldest first.
  word_t power_q [$];
  int    error_cnt;
  int    cycle_cnt;
  bit    quiet;

  modular_exponentiation u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .msg_i       (msg_if),
    .res_o       (res_if)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Right-to-left square-and-multiply with exact double-width products.
  function automatic word_t predict_power(input word_t base, input word_t modulus,
                                          input word_t exponent);
    dword_t m;
    dword_t sq;
    dword_t acc;
    if (exponent == '0) return word_t'(1);
    if (modulus == '0) return '0;
    m   = dword_t'(modulus);
    sq  = dword_t'(base) % m;
    acc = dword_t'(1);
    for (int i = 0; i < Width; i++) begin
      if (exponent[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return word_t'(acc);
  endfunction

  // Write both registers on consecutive cycles; called at a falling edge.
  task automatic write_config(input word_t modulus, input word_t exponent);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgModulus;
    cfg_wdata_i <= modulus;
    @(negedge clk_i);
    cfg_index_i <= CfgExponent;
    cfg_wdata_i <= exponent;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_modulus  = modulus;
    cur_exponent = exponent;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every owed power has been transferred.
  task automatic wait_drained();
    msg_if.valid <= 1'b0;
    while (power_q.size() != 0) @(negedge clk_i);
  endtask

  // Offer one message, with random idle cycles first; returns at a falling edge.
  task automatic send_message(input word_t message, input word_t power);
    while (!quiet && $urandom_range(99) < 34) begin
      msg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_if.valid   <= 1'b1;
    msg_if.message <= message;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    power_q.push_back(power);
    @(negedge clk_i);
  endtask

  // Result side: random backpressure, changed at the falling edge.
  always @(negedge clk_i) begin
    res_if.ready <= !(!quiet && $urandom_range(99) < 34);
  end

  // Compare each result transfer with the oldest owed power.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (power_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time,
                 res_if.power_result);
        error_cnt++;
      end else begin
        if (res_if.power_result !== power_q[0]) begin
          $display("%0t: power_result mismatch, expected %h, actual %h", $time,
                   power_q[0], res_if.power_result);
          error_cnt++;
        end
        void'(power_q.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases of fixed configuration.
  initial begin
    word_t modulus;
    word_t exponent;
    word_t message;
    word_t power;

    error_cnt      = 0;
    cycle_cnt      = 0;
    quiet          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CfgModulus;
    cfg_wdata_i    = '0;
    msg_if.valid   = 1'b0;
    msg_if.message = '0;
    res_if.ready   = 1'b0;
    cur_modulus    = word_t'(1);
    cur_exponent   = word_t'(1);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows; the configuration is rewritten only when a row changes it.
    for (int r = 0; r < NumDir; r++) begin
      if (DirTab[r].modulus != cur_modulus || DirTab[r].exponent != cur_exponent) begin
        wait_drained();
        write_config(DirTab[r].modulus, DirTab[r].exponent);
      end
      power = DirTab[r].known ? DirTab[r].power
                              : predict_power(DirTab[r].message, cur_modulus, cur_exponent);
      send_message(DirTab[r].message, power);
    end

    // Random phases; one phase runs without any idling on either side.
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      case ($urandom_range(5))
        0:       modulus = $urandom;
        1:       modulus = $urandom_range(1, 255);
        2:       modulus = '1;
        3:       modulus = $urandom_range(1, 65535);
        4:       modulus = $urandom | 32'h8000_0001;
        default: modulus = 32'hFFFF_FFFB;
      endcase
      case ($urandom_range(5))
        0, 1:    exponent = $urandom;
        2:       exponent = $urandom_range(0, 15);
        3:       exponent = '1;
        4:       exponent = 32'h0001_0001;
        default: exponent = '0;
      endcase
      write_config(modulus, exponent);
      quiet = (p == 2);
      for (int k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: message = (cur_modulus == '0) ? word_t'($urandom)
                                                          : word_t'($urandom) % cur_modulus;
          6, 7:             message = $urandom;
          8:                message = cur_modulus - word_t'(1);
          default: begin
            case ($urandom_range(2))
              0:       message = '0;
              1:       message = word_t'(1);
              default: message = '1;
            endcase
          end
        endcase
        send_message(message, predict_power(message, cur_modulus, cur_exponent));
      end
      quiet = 1'b0;
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: modular_exponentiation.f
rtl/core/me_pkg.sv
rtl/core/me_if.sv
rtl/core/me_mulmod.sv
rtl/core/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
